// File: rtl/smhm_pkg.sv
package smhm_pkg;

  // Width of one sample and of the mean.
  localparam int unsigned DATA_W = 16;
  // Width of the window sum; the sum wraps at this width.
  localparam int unsigned SUM_W = 22;
  // Width of the reported sample count.
  localparam int unsigned USED_W = 7;
  // Width of the divider step counter.
  localparam int unsigned ITER_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_SCAN,
    S_DIV,
    S_DONE
  } smhm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // store an accepted sample
    logic prep;    // latch window bounds and clear the accumulator
    logic scan;    // shift the sorted row by one and accumulate
    logic div;     // one restoring division step
    logic finish;  // load the result register and clear the block state
  } smhm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the current scan step is the last one
    logic div_done;   // the current division step is the last one
  } smhm_sts_t;

endpackage

// File: rtl/smhm_ctrl.sv
module smhm_ctrl
  import smhm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tlast,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  smhm_sts_t  sts,
  output smhm_cmd_t  cmd
);

  smhm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc;
  logic        slot_free;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (in_acc && in_tlast) state_nxt = S_PREP;
      S_PREP: state_nxt = S_SCAN;
      S_SCAN: if (sts.scan_done) state_nxt = S_DIV;
      S_DIV:  if (sts.div_done) state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_PREP: cmd.prep = 1'b1;
      S_SCAN: cmd.scan = 1'b1;
      S_DIV:  cmd.div  = 1'b1;
      S_DONE: cmd.finish = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while pending");

  // The last sample of a block always starts the computation.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == S_PREP))
    else $error("last sample did not start the computation");

  // The end of the division always leads to the result stage.
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_done) |=> (state_r == S_DONE))
    else $error("division end not followed by result stage");

  // No sample is taken while a block is being computed.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !cmd.load)
    else $error("sample stored during computation");

endmodule

// File: rtl/smhm_dp.sv
module smhm_dp
  import smhm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smhm_cmd_t         cmd,
  input  logic [DATA_W-1:0] sample,
  output smhm_sts_t         sts,
  output logic [DATA_W-1:0] trimmed_mean,
  output logic [USED_W-1:0] samples_used,
  output logic              overflowed
);

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  // Sorted row, largest value in cell 0.
  logic [DATA_W-1:0] cell_r   [MAX_SAMPLES];
  logic [DATA_W-1:0] cell_nxt [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] keep;

  logic [CW-1:0]     count_r;
  logic              drop_r;
  logic              full;

  logic [CW-1:0]     lo_r, end_r, pos_r, div_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CW-1:0]     rem_r;
  logic [ITER_W-1:0] iter_r;

  logic [CW:0]       trial;
  logic              trial_ge;

  logic [CW-1:0]     lo_nxt, len_nxt, div_nxt;

  logic [DATA_W-1:0] mean_r;
  logic [USED_W-1:0] used_r;
  logic              ovf_r;

  assign full = (count_r == CW'(MAX_SAMPLES));

  // Insertion into the sorted row: every cell compares against the new sample.
  always_comb begin
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      keep[k] = (CW'(k) < count_r) && (cell_r[k] >= sample);
    end
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      if (cmd.scan) begin
        cell_nxt[k] = (k == MAX_SAMPLES - 1) ? cell_r[k] : cell_r[(k + 1) % MAX_SAMPLES];
      end else if (keep[k]) begin
        cell_nxt[k] = cell_r[k];
      end else if (k == 0) begin
        cell_nxt[k] = sample;
      end else if (keep[(k + MAX_SAMPLES - 1) % MAX_SAMPLES]) begin
        cell_nxt[k] = sample;
      end else begin
        cell_nxt[k] = cell_r[(k + MAX_SAMPLES - 1) % MAX_SAMPLES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.load && !full) || cmd.scan) begin
      for (int k = 0; k < MAX_SAMPLES; k++) begin
        cell_r[k] <= cell_nxt[k];
      end
    end
  end

  // Window bounds: one and two samples are plain averages.
  always_comb begin
    if (count_r == CW'(1)) begin
      lo_nxt  = '0;
      len_nxt = CW'(1);
      div_nxt = CW'(1);
    end else if (count_r == CW'(2)) begin
      lo_nxt  = '0;
      len_nxt = CW'(2);
      div_nxt = CW'(2);
    end else begin
      lo_nxt  = count_r >> 2;
      len_nxt = count_r >> 1;
      div_nxt = count_r >> 1;
    end
  end

  // Restoring division step on the accumulated sum.
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_r});

  assign sts.scan_done = (pos_r == end_r - CW'(1));
  assign sts.div_done  = (iter_r == ITER_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      lo_r   <= lo_nxt;
      end_r  <= lo_nxt + len_nxt;
      div_r  <= div_nxt;
      pos_r  <= '0;
      quo_r  <= '0;
      rem_r  <= '0;
      iter_r <= '0;
    end
    if (cmd.scan) begin
      pos_r <= pos_r + CW'(1);
      if (pos_r >= lo_r) quo_r <= quo_r + SUM_W'(cell_r[0]);
    end
    if (cmd.div) begin
      iter_r <= iter_r + ITER_W'(1);
      quo_r  <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r  <= trial_ge ? CW'(trial - {1'b0, div_r}) : trial[CW-1:0];
    end
    if (cmd.finish) begin
      mean_r <= quo_r[DATA_W-1:0];
      used_r <= USED_W'(count_r);
      ovf_r  <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.finish) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.load) begin
      if (full) drop_r <= 1'b1;
      else count_r <= count_r + CW'(1);
    end
  end

  assign trimmed_mean = mean_r;
  assign samples_used = used_r;
  assign overflowed   = ovf_r;

endmodule

// File: rtl/sorted_middle_half_mean_top.sv
// Sequence: the last sample of a block starts set-up, the window scan, 22 divider
// steps and the hand-over to the result register, in that order.
// Throughput: one sample request per cycle while loading; after the last sample
// the input is held off through that whole sequence, and longer while an earlier
// result is still waiting downstream.
// Reset: synchronous, active low; clears the controller, count and overflow flag only.
module sorted_middle_half_mean_top
  import smhm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,   // last_sample
  // Result requests.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] trimmed_mean, [22:16] samples_used, [23] zero
  output logic        out_tuser   // overflowed
);

  // The block is split into a small controller and a datapath. While loading,
  // each accepted sample is inserted into a row of sorted cells on acceptance,
  // largest value first; samples that arrive with the row full are dropped
  // and remembered in the overflow flag.
  //
  // After the last sample the controller latches the window bounds, then
  // shifts the row towards cell 0 one position per cycle, adding those
  // values that fall inside the middle-half window. The sum (wrapping at
  // 22 bits) is then divided by the window length with a restoring divider
  // producing one quotient bit per cycle.
  //
  // The result register sits apart from the computation: a finished result
  // may wait for the downstream side while the next block is already loading.

  smhm_cmd_t         cmd;
  smhm_sts_t         sts;
  logic [DATA_W-1:0] trimmed_mean;
  logic [USED_W-1:0] samples_used;
  logic              overflowed;

  smhm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  smhm_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sample       (in_tdata),
    .sts          (sts),
    .trimmed_mean (trimmed_mean),
    .samples_used (samples_used),
    .overflowed   (overflowed)
  );

  assign out_tdata = {1'b0, samples_used, trimmed_mean};
  assign out_tuser = overflowed;

endmodule
